// ----- hw/rtl/srbp_pkg.sv -----
// ----------------------------------------------------------------------------
// srbp_pkg
// Shared types and constants of the signed rice bit packer.
// ----------------------------------------------------------------------------
package srbp_pkg;

  localparam int VALUE_WIDTH          = 48;
  localparam int K_WIDTH              = 6;
  localparam int OFS_WIDTH            = 3;
  localparam int CODE_BITS_WIDTH      = 9;
  localparam int MAX_ITEMS            = 40;
  localparam int ITEM_CNT_WIDTH       = 6;
  localparam int MAX_QUOTIENT_DEFAULT = 255;

  localparam int CFG_DATA_WIDTH = 64;
  localparam int CFG_ADDR_WIDTH = 5;

  localparam logic [VALUE_WIDTH-1:0] DEFAULT_THRESHOLD = 48'd598987900929;
  localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET     =
    (DEFAULT_THRESHOLD << 1) - VALUE_WIDTH'(1);
  localparam logic [K_WIDTH-1:0]     RICE_K_RESET      = 6'd8;
  localparam logic [OFS_WIDTH-1:0]   START_OFFSET_RESET = 3'd0;
  localparam logic [K_WIDTH-1:0]     K_MAX             = K_WIDTH'(VALUE_WIDTH - 1);
  localparam logic [CODE_BITS_WIDTH-1:0] CODE_BITS_MAX = '1;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_MODULUS      = 2'd0,
    REG_RICE_K       = 2'd1,
    REG_START_OFFSET = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] coeff_value;
    logic                   block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]                 out_byte;
    logic                       byte_valid;
    logic [CODE_BITS_WIDTH-1:0] code_bits;
    logic                       overflow;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc1;
    logic calc2;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
    logic item;
  } dp_stat_t;

endpackage

// ----- hw/rtl/srbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// srbp_ctrl
// Sequencer of the packer: load, calc1, calc2, one byte step per free cycle.
// ----------------------------------------------------------------------------
module srbp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output srbp_pkg::dp_cmd_t  cmd,
  input  srbp_pkg::dp_stat_t stat
);
  import srbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.calc1 = (state_r == ST_CALC1);
    cmd.calc2 = (state_r == ST_CALC2);
    cmd.step  = (state_r == ST_EMIT) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CALC1;
      ST_CALC1: state_nxt = ST_CALC2;
      ST_CALC2: state_nxt = ST_EMIT;
      ST_EMIT:  if (cmd.step && stat.finish) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (cmd.step) begin
      out_valid_nxt = stat.item;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/srbp_datapath.sv -----
// ----------------------------------------------------------------------------
// srbp_datapath
// Sign fold, quotient split and byte assembly of the rice code.
// ----------------------------------------------------------------------------
module srbp_datapath #(
  parameter int MAX_QUOTIENT = srbp_pkg::MAX_QUOTIENT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srbp_pkg::dp_cmd_t                   cmd,
  output srbp_pkg::dp_stat_t                  stat,
  input  srbp_pkg::in_item_t                  in_data,
  input  logic [srbp_pkg::VALUE_WIDTH-1:0]    modulus,
  input  logic [srbp_pkg::K_WIDTH-1:0]        rice_k,
  input  logic [srbp_pkg::OFS_WIDTH-1:0]      start_offset,
  output srbp_pkg::out_item_t                 out_data
);
  import srbp_pkg::*;

  localparam int QW    = $clog2(MAX_QUOTIENT + 1);
  localparam int LW    = $clog2(MAX_QUOTIENT + VALUE_WIDTH + 2);
  localparam int CLW   = (LW > CODE_BITS_WIDTH) ? LW : CODE_BITS_WIDTH;
  localparam int RIX_W = $clog2(VALUE_WIDTH);

  // item and block state
  logic [VALUE_WIDTH-1:0]     v_r;
  logic                       end_r;
  logic                       in_block_r;
  logic [2:0]                 bitpos_r;
  logic [7:0]                 partial_r;
  logic                       sign_r;
  logic [VALUE_WIDTH-1:0]     mag_r;
  logic [K_WIDTH-1:0]         k_r;
  logic [QW-1:0]              q_r;
  logic [LW-1:0]              len_r;
  logic                       ovf_r;
  logic [CODE_BITS_WIDTH-1:0] codelen_r;
  logic [LW-1:0]              pos_r;
  logic [ITEM_CNT_WIDTH-1:0]  cnt_r;
  out_item_t                  out_r;

  // first compute cycle
  logic [VALUE_WIDTH:0]   thr_sum;
  logic [VALUE_WIDTH-1:0] thr;
  logic                   sign_c;
  logic [VALUE_WIDTH-1:0] mag_c;
  logic [K_WIDTH-1:0]     k_c;

  always_comb begin
    thr_sum = {1'b0, modulus} + (VALUE_WIDTH+1)'(1);
    thr     = thr_sum[VALUE_WIDTH:1];
    sign_c  = (v_r > thr);
    mag_c   = sign_c ? (modulus - v_r) : v_r;
    k_c     = (rice_k > K_MAX) ? K_MAX : rice_k;
  end

  // second compute cycle
  logic [VALUE_WIDTH-1:0] shifted;
  logic                   ovf_c;
  logic [QW-1:0]          q_c;
  logic [LW-1:0]          len_c;
  logic [CLW-1:0]         len_ext;
  logic [CODE_BITS_WIDTH-1:0] codelen_c;

  always_comb begin
    shifted   = mag_r >> k_r;
    ovf_c     = (shifted > VALUE_WIDTH'(MAX_QUOTIENT));
    q_c       = shifted[QW-1:0];
    len_c     = LW'(q_c) + LW'(k_r) + LW'(2);
    len_ext   = CLW'(len_c);
    codelen_c = (len_ext > CLW'(CODE_BITS_MAX)) ? CODE_BITS_MAX
                                                 : len_ext[CODE_BITS_WIDTH-1:0];
  end

  // byte step
  logic [LW-1:0]  rem;
  logic [3:0]     room;
  logic [3:0]     n;
  logic [3:0]     fill;
  logic           full;
  logic [LW-1:0]  r_after;
  logic [LW-1:0]  qx;
  logic [LW-1:0]  idx;
  logic [LW-1:0]  rix;
  logic [7:0]     bits;
  logic [7:0]     byte_nxt;
  logic           flush;
  logic           room_left;
  logic           item_c;
  logic           last_c;

  always_comb begin
    rem     = len_r - pos_r;
    room    = 4'd8 - {1'b0, bitpos_r};
    n       = (rem < LW'(room)) ? rem[3:0] : room;
    fill    = {1'b0, bitpos_r} + n;
    full    = fill[3];
    r_after = rem - LW'(n);
    qx      = LW'(q_r);
    bits    = '0;
    idx     = '0;
    rix     = '0;
    for (int s = 0; s < 8; s++) begin
      if ((4'(s) >= {1'b0, bitpos_r}) && (4'(s) < fill)) begin
        idx = pos_r + LW'(s) - LW'(bitpos_r);
        rix = idx - qx - LW'(2);
        if (idx == '0) begin
          bits[s] = sign_r;
        end else if (idx <= qx) begin
          bits[s] = 1'b1;
        end else if (idx == qx + LW'(1)) begin
          bits[s] = 1'b0;
        end else if (rix < LW'(VALUE_WIDTH)) begin
          bits[s] = mag_r[rix[RIX_W-1:0]];
        end
      end
    end
    byte_nxt  = partial_r | bits;
    flush     = end_r && (fill[2:0] != 3'd0);
    room_left = (cnt_r < ITEM_CNT_WIDTH'(MAX_ITEMS));
    if (full) begin
      item_c = room_left;
      last_c = (r_after == '0) || ((r_after < LW'(8)) && !end_r)
               || (cnt_r == ITEM_CNT_WIDTH'(MAX_ITEMS - 1));
    end else if (flush) begin
      item_c = room_left;
      last_c = 1'b1;
    end else begin
      // an item that completes nothing still gives one empty beat
      item_c = (cnt_r == '0);
      last_c = 1'b1;
    end
  end

  assign stat.finish = !full;
  assign stat.item   = item_c;
  assign out_data    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
      bitpos_r   <= '0;
      partial_r  <= '0;
    end else begin
      if (cmd.load && !in_block_r) begin
        in_block_r <= 1'b1;
        bitpos_r   <= start_offset;
        partial_r  <= '0;
      end
      if (cmd.step) begin
        if (full) begin
          bitpos_r  <= '0;
          partial_r <= '0;
        end else if (end_r) begin
          in_block_r <= 1'b0;
          bitpos_r   <= '0;
          partial_r  <= '0;
        end else begin
          bitpos_r  <= fill[2:0];
          partial_r <= byte_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r   <= in_data.coeff_value;
      end_r <= in_data.block_end;
    end
    if (cmd.calc1) begin
      sign_r <= sign_c;
      mag_r  <= mag_c;
      k_r    <= k_c;
    end
    if (cmd.calc2) begin
      q_r       <= q_c;
      ovf_r     <= ovf_c;
      len_r     <= ovf_c ? '0 : len_c;
      codelen_r <= ovf_c ? '0 : codelen_c;
      pos_r     <= '0;
      cnt_r     <= '0;
    end
    if (cmd.step) begin
      if (full) begin
        pos_r <= pos_r + LW'(n);
      end
      if (item_c) begin
        cnt_r              <= cnt_r + ITEM_CNT_WIDTH'(1);
        out_r.out_byte     <= (full || flush) ? byte_nxt : 8'd0;
        out_r.byte_valid   <= full || flush;
        out_r.code_bits    <= codelen_r;
        out_r.overflow     <= ovf_r;
        out_r.last         <= last_c;
      end
    end
  end

endmodule

// ----- hw/rtl/signed_rice_bit_packer_top.sv -----
// ----------------------------------------------------------------------------
// signed_rice_bit_packer_top
// Signed rice coder that packs code bits lsb-first into a byte stream.
//
//   channel | direction | handshake               | payload
//   in_     | input     | in_valid / in_stall     | in_item_t  (coeff, block end)
//   out_    | output    | out_valid / out_stall   | out_item_t (one byte per beat)
//   cfg_    | input     | apb, pready tied high   | modulus, rice_k, start_offset
//
// an item passes through the accepting cycle, the compute states calc1 and
// calc2, one byte step per completed byte and a closing step that flushes
// the partial byte or gives the empty beat.
// reset is synchronous on rst_n and leaves no block open.
// each cycle that a beat waits under out_stall holds the byte step;
// in_stall is high from acceptance until the closing step.
// ----------------------------------------------------------------------------
module signed_rice_bit_packer_top #(
  parameter int MAX_QUOTIENT = srbp_pkg::MAX_QUOTIENT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  srbp_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output srbp_pkg::out_item_t                  out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [srbp_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [srbp_pkg::CFG_DATA_WIDTH-1:0]  cfg_pwdata,
  output logic [srbp_pkg::CFG_DATA_WIDTH-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);
  import srbp_pkg::*;

  logic [VALUE_WIDTH-1:0] modulus_r;
  logic [K_WIDTH-1:0]     rice_k_r;
  logic [OFS_WIDTH-1:0]   start_offset_r;
  reg_idx_t               reg_idx;
  logic                   cfg_wr;
  dp_cmd_t                cmd;
  dp_stat_t               stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r      <= MODULUS_RESET;
      rice_k_r       <= RICE_K_RESET;
      start_offset_r <= START_OFFSET_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODULUS:      modulus_r      <= cfg_pwdata[VALUE_WIDTH-1:0];
        REG_RICE_K:       rice_k_r       <= cfg_pwdata[K_WIDTH-1:0];
        REG_START_OFFSET: start_offset_r <= cfg_pwdata[OFS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS:      cfg_prdata = CFG_DATA_WIDTH'(modulus_r);
      REG_RICE_K:       cfg_prdata = CFG_DATA_WIDTH'(rice_k_r);
      REG_START_OFFSET: cfg_prdata = CFG_DATA_WIDTH'(start_offset_r);
      default:          cfg_prdata = '0;
    endcase
  end

  srbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  srbp_datapath #(
    .MAX_QUOTIENT (MAX_QUOTIENT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_data      (in_data),
    .modulus      (modulus_r),
    .rice_k       (rice_k_r),
    .start_offset (start_offset_r),
    .out_data     (out_data)
  );

  // an empty beat only ever closes an item
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last)
    else $error("empty beat without last");

  // an overflowed coefficient codes no bits
  a_ovf_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.code_bits == '0)
    else $error("overflow beat with nonzero code length");

  // one item at a time: input closes right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open in the cycle after acceptance");

endmodule

// ----- verif/signed_rice_bit_packer_top_tb.sv -----
// ----------------------------------------------------------------------------
// signed_rice_bit_packer_top_tb
// Self-checking bench for the signed rice bit packer. A directed table runs
// the corner cases first: quotient at and above the limit, sign threshold,
// out-of-range values, flush with and without pending bits, start offsets,
// saturated rice_k and both modulus extremes. Random phases follow under
// varied register settings and handshake pressure. Every output beat is
// compared against a typed row's beat or an in-bench partial-byte coder.
// ----------------------------------------------------------------------------
module signed_rice_bit_packer_top_tb;
  import srbp_pkg::*;

  localparam int MAX_Q           = MAX_QUOTIENT_DEFAULT;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20000;

  localparam in_item_t  NO_COEFF = '0;
  localparam out_item_t NO_BEAT  = '0;
  // overflowed code with nothing to flush
  localparam out_item_t OVF_BEAT = '{8'h00, 1'b0, 9'd0, 1'b1, 1'b1};

  typedef struct packed {
    logic      is_cfg;
    reg_idx_t  idx;
    logic [63:0] val;
    in_item_t  coeff;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data     = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_psel    = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_prdata;
  logic                      cfg_pready;

  signed_rice_bit_packer_top #(
    .MAX_QUOTIENT(MAX_Q)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // coder state mirrored in the bench
  logic [VALUE_WIDTH-1:0] cfg_modulus   = MODULUS_RESET;
  logic [K_WIDTH-1:0]     cfg_rice_k    = RICE_K_RESET;
  logic [OFS_WIDTH-1:0]   cfg_start_ofs = START_OFFSET_RESET;
  logic [7:0]             acc_byte      = '0;
  int unsigned            acc_pos       = 0;
  bit                     blk_open      = 1'b0;

  logic [7:0]  packed_bytes[$];
  out_item_t   coded_beats[$];
  out_item_t   beats_due[$];
  int unsigned err_cnt   = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("signed_rice_bit_packer_top test failed");
    $finish;
  end

  function automatic void pack_bit(input logic b);
    acc_byte[acc_pos] = b;
    acc_pos++;
    if (acc_pos == 8) begin
      packed_bytes.push_back(acc_byte);
      acc_byte = '0;
      acc_pos  = 0;
    end
  endfunction

  function automatic void encode_coeff(input in_item_t it);
    logic [VALUE_WIDTH:0]   thr_wide;
    logic [VALUE_WIDTH-1:0] thr;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] quo;
    int unsigned            k;
    int unsigned            clen;
    int unsigned            j;
    logic                   sgn;
    logic                   ovf;
    out_item_t              beat;
    thr_wide = ({1'b0, cfg_modulus} + 1'b1) >> 1;
    thr      = thr_wide[VALUE_WIDTH-1:0];
    k        = (cfg_rice_k > K_MAX) ? K_MAX : cfg_rice_k;
    packed_bytes.delete();
    coded_beats.delete();
    if (!blk_open) begin
      acc_pos  = cfg_start_ofs;
      acc_byte = '0;
      blk_open = 1'b1;
    end
    sgn  = it.coeff_value > thr;
    mag  = sgn ? cfg_modulus - it.coeff_value : it.coeff_value;
    quo  = mag >> k;
    ovf  = quo > MAX_Q;
    clen = 0;
    if (!ovf) begin
      clen = quo + k + 2;
      if (clen > CODE_BITS_MAX) clen = CODE_BITS_MAX;
      pack_bit(sgn);
      for (j = 0; j < quo; j++) pack_bit(1'b1);
      pack_bit(1'b0);
      for (j = 0; j < k; j++) pack_bit(mag[j]);
    end
    if (it.block_end) begin
      if (acc_pos != 0) packed_bytes.push_back(acc_byte);
      acc_byte = '0;
      acc_pos  = cfg_start_ofs;
      blk_open = 1'b0;
    end
    beat.code_bits = clen[CODE_BITS_WIDTH-1:0];
    beat.overflow  = ovf;
    if (packed_bytes.size() == 0) begin
      beat.out_byte   = '0;
      beat.byte_valid = 1'b0;
      beat.last       = 1'b1;
      coded_beats.push_back(beat);
    end else begin
      foreach (packed_bytes[i]) begin
        beat.out_byte   = packed_bytes[i];
        beat.byte_valid = 1'b1;
        beat.last       = (i == packed_bytes.size() - 1);
        coded_beats.push_back(beat);
      end
    end
  endfunction

  function automatic in_item_t pick_coeff();
    in_item_t               it;
    logic [VALUE_WIDTH:0]   thr_wide;
    logic [VALUE_WIDTH-1:0] thr;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] rem_mask;
    int unsigned            k;
    int unsigned            q;
    int unsigned            pick;
    thr_wide = ({1'b0, cfg_modulus} + 1'b1) >> 1;
    thr      = thr_wide[VALUE_WIDTH-1:0];
    k        = (cfg_rice_k > K_MAX) ? K_MAX : cfg_rice_k;
    pick     = $urandom_range(99);
    if (pick < 70) begin
      // well-formed magnitude, mostly short quotients
      q        = ($urandom_range(15) == 0) ? $urandom_range(MAX_Q + 1) : $urandom_range(6);
      rem_mask = (48'd1 << k) - 1'b1;
      mag      = (48'(q) << k) | ({$urandom, $urandom} & rem_mask);
      if (mag > thr) mag = mag % (thr + 1'b1);
      it.coeff_value = ($urandom_range(1) && mag != 0) ? cfg_modulus - mag : mag;
    end else if (pick < 85) begin
      it.coeff_value = {$urandom, $urandom} % cfg_modulus;
    end else if (pick < 93) begin
      case ($urandom_range(3))
        0:       it.coeff_value = thr;
        1:       it.coeff_value = thr + 1'b1;
        2:       it.coeff_value = cfg_modulus - 1'b1;
        default: it.coeff_value = cfg_modulus;
      endcase
    end else begin
      it.coeff_value = {$urandom, $urandom};
    end
    it.block_end = ($urandom_range(5) == 0);
    return it;
  endfunction

  task automatic send_coeff(input in_item_t it, input logic typed, input out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    encode_coeff(it);
    if (typed) begin
      beats_due.push_back(want);
    end else begin
      foreach (coded_beats[i]) beats_due.push_back(coded_beats[i]);
    end
  endtask

  task automatic settle_outputs();
    int unsigned w;
    in_valid <= 1'b0;
    w = 0;
    while (beats_due.size() != 0 && w < DRAIN_CYCLES) begin
      @(posedge clk);
      w++;
    end
    if (beats_due.size() != 0) begin
      $error("%0d result beats never arrived", beats_due.size());
      err_cnt++;
      beats_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    logic [63:0] kept;
    case (idx)
      REG_MODULUS: begin
        cfg_modulus = val[VALUE_WIDTH-1:0];
        kept        = 64'(val[VALUE_WIDTH-1:0]);
      end
      REG_RICE_K: begin
        cfg_rice_k = val[K_WIDTH-1:0];
        kept       = 64'(val[K_WIDTH-1:0]);
      end
      REG_START_OFFSET: begin
        cfg_start_ofs = val[OFS_WIDTH-1:0];
        kept          = 64'(val[OFS_WIDTH-1:0]);
      end
      default: kept = '0;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read back through a second transfer
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== kept) begin
      $error("cfg readback of %s: expected %h, got %h", idx.name(), kept, cfg_prdata);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [63:0] m;
    logic [63:0] k;
    case ($urandom_range(4))
      0:       m = 64'd3;
      1:       m = 64'hffff_ffff_ffff;
      2:       m = 64'(MODULUS_RESET);
      3:       m = 64'($urandom_range(1000, 3) | 1);
      default: m = ({$urandom, $urandom} & 64'hffff_ffff_ffff) | 64'd1;
    endcase
    if (m < 3) m = 64'd3;
    case ($urandom_range(5))
      0:       k = 64'd0;
      1:       k = 64'd47;
      2:       k = 64'd63;
      3:       k = 64'($urandom_range(63));
      default: k = 64'($urandom_range(12));
    endcase
    write_reg(REG_MODULUS, m);
    write_reg(REG_RICE_K, k);
    write_reg(REG_START_OFFSET, 64'($urandom_range(7)));
  endtask

  always @(posedge clk) begin : out_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected: out_byte %h", out_data.out_byte);
        err_cnt++;
      end else begin
        want = beats_due.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          err_cnt++;
        end
        if (out_data.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, out_data.byte_valid);
          err_cnt++;
        end
        if (out_data.code_bits !== want.code_bits) begin
          $error("code_bits: expected %0d, got %0d", want.code_bits, out_data.code_bits);
          err_cnt++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_data.overflow);
          err_cnt++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          err_cnt++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  initial begin : stimulus
    dir_row_t dir_rows [25];
    int       p;
    dir_rows = '{
      // reset settings: modulus default, k 8, offset 0
      '{1'b0, REG_NONE, 64'd0, '{48'd0, 1'b0}, 1'b1, '{8'h00, 1'b1, 9'd10, 1'b0, 1'b1}},
      '{1'b0, REG_NONE, 64'd0, '{48'd65536, 1'b0}, 1'b1, OVF_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd65535, 1'b0}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd0, 1'b1}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd1197975801856, 1'b0}, 1'b1,
        '{8'h05, 1'b1, 9'd10, 1'b0, 1'b1}},
      '{1'b0, REG_NONE, 64'd0, '{48'd598987900929, 1'b0}, 1'b1, OVF_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd598987900930, 1'b0}, 1'b1, OVF_BEAT},
      // overflow while two bits are pending: flush still emits them
      '{1'b0, REG_NONE, 64'd0, '{48'hffff_ffff_ffff, 1'b1}, 1'b1,
        '{8'h00, 1'b1, 9'd0, 1'b1, 1'b1}},
      '{1'b0, REG_NONE, 64'd0, '{48'd65536, 1'b1}, 1'b1, OVF_BEAT},
      '{1'b1, REG_RICE_K, 64'd0, NO_COEFF, 1'b0, NO_BEAT},
      '{1'b1, REG_START_OFFSET, 64'd7, NO_COEFF, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd0, 1'b1}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd255, 1'b0}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd256, 1'b1}, 1'b0, NO_BEAT},
      '{1'b1, REG_MODULUS, 64'd3, NO_COEFF, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd0, 1'b0}, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b1}},
      '{1'b0, REG_NONE, 64'd0, '{48'd2, 1'b0}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'd3, 1'b1}, 1'b0, NO_BEAT},
      '{1'b1, REG_MODULUS, 64'hffff_ffff_ffff, NO_COEFF, 1'b0, NO_BEAT},
      // k above the value width saturates
      '{1'b1, REG_RICE_K, 64'd63, NO_COEFF, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'h7fff_ffff_ffff, 1'b1}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'h8000_0000_0001, 1'b0}, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'h8000_0000_0000, 1'b1}, 1'b0, NO_BEAT},
      '{1'b1, REG_RICE_K, 64'd47, NO_COEFF, 1'b0, NO_BEAT},
      '{1'b0, REG_NONE, 64'd0, '{48'hffff_ffff_ffff, 1'b1}, 1'b0, NO_BEAT}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle_outputs();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_coeff(dir_rows[i].coeff, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    settle_outputs();

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct  = 26;
          stall_pct = 26;
        end
      endcase
      pick_settings();
      repeat (ITEMS_PER_PHASE) send_coeff(pick_coeff(), 1'b0, NO_BEAT);
      settle_outputs();
    end

    if (err_cnt == 0) begin
      $display("signed_rice_bit_packer_top test passed");
    end else begin
      $display("signed_rice_bit_packer_top test failed");
    end
    $finish;
  end

endmodule
